/* design/pcx_pkg.sv */
package pcx_pkg;

    localparam int PAL_ENTRIES = 256;
    localparam int PAL_AW      = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;

    localparam logic [1:0] REQ_PAL   = 2'd0;
    localparam logic [1:0] REQ_DATA  = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_LBYTES = 2'd2;

    localparam int CFG_DW = 17;

    localparam logic [7:0]  RUN_MARK     = 8'hC0;
    localparam int          RUN_W        = 6;
    localparam logic [16:0] RST_WIDTH    = 17'd320;
    localparam logic [16:0] RST_HEIGHT   = 17'd200;
    localparam logic [15:0] RST_LBYTES   = 16'd320;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

endpackage

/* design/pcx_in_if.sv */
interface pcx_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] pal_index;
    logic [7:0] pal_red;
    logic [7:0] pal_green;
    logic [7:0] pal_blue;
    logic [7:0] data_byte;

    modport source (
        output valid, req_type, pal_index, pal_red, pal_green, pal_blue, data_byte,
        input  ready
    );
    modport sink (
        input  valid, req_type, pal_index, pal_red, pal_green, pal_blue, data_byte,
        output ready
    );
endinterface

/* design/pcx_out_if.sv */
interface pcx_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] pixel_col;
    logic [15:0] pixel_row;
    logic        last_of_run;
    logic        image_end;

    modport source (
        output valid, red, green, blue, pixel_col, pixel_row, last_of_run, image_end,
        input  ready
    );
    modport sink (
        input  valid, red, green, blue, pixel_col, pixel_row, last_of_run, image_end,
        output ready
    );
endinterface

/* design/pcx_rle_palette_decoder.sv */
// An accepted data byte passes the registered palette read, then the output register,
//   which loads when o_pix is ready or empty. Throughput: one pixel per cycle while
//   o_pix.ready holds; the input is not ready until the current run is through.
// Palette writes, image starts and run markers are handled without leaving the idle state.
// Reset (i_rst_n low, synchronous) clears counters, pending run and output valid and
//   restores the size registers; the palette RAM keeps its contents.
module pcx_rle_palette_decoder (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    pcx_in_if.sink                     i_req,
    pcx_out_if.source                  o_pix,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [pcx_pkg::CFG_DW-1:0] i_cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                      r_state, n_state;
    logic [16:0]               r_width, r_height;
    logic [15:0]               r_lb;
    logic                      r_pend, n_pend;
    logic [pcx_pkg::RUN_W-1:0] r_pcnt, n_pcnt;
    logic [pcx_pkg::RUN_W-1:0] r_rem, n_rem;
    logic [15:0]               r_col, n_col;
    logic [16:0]               r_row, n_row;
    logic                      r_done, n_done;
    logic                      r_out_valid, n_out_valid;

    pcx_pkg::t_rgb r_out_rgb;
    logic [15:0]   r_out_col, r_out_row;
    logic          r_out_last, r_out_end;

    pcx_pkg::t_rgb w_pal_rgb;
    pcx_pkg::t_rgb w_wr_rgb;
    logic          w_acc, w_is_data, w_is_pal;
    logic          w_vis, w_slot, w_emit, w_last, w_end;
    logic [16:0]   w_col_p1, w_col_rem, w_row_p1;
    logic          w_lb_zero, w_rowend, w_reach, w_fin;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_is_data   = w_acc && (i_req.req_type == pcx_pkg::REQ_DATA);
    assign w_is_pal    = w_acc && (i_req.req_type == pcx_pkg::REQ_PAL);

    assign w_wr_rgb = '{red: i_req.pal_red, green: i_req.pal_green, blue: i_req.pal_blue};

    pcx_palette u_pal (
        .i_clk    (i_clk),
        .i_wr_en  (w_is_pal),
        .i_wr_idx (i_req.pal_index),
        .i_wr_rgb (w_wr_rgb),
        .i_rd_en  (w_is_data),
        .i_rd_idx (i_req.data_byte),
        .o_rd_rgb (w_pal_rgb)
    );

    // per-pixel run step
    assign w_vis     = {1'b0, r_col} < r_width;
    assign w_col_p1  = {1'b0, r_col} + 17'd1;
    assign w_col_rem = {1'b0, r_col} + 17'(r_rem);
    assign w_row_p1  = r_row + 17'd1;
    assign w_lb_zero = (r_lb == 16'd0);
    assign w_rowend  = w_lb_zero || (w_col_p1 >= {1'b0, r_lb});
    // does the rest of this run reach the row end
    assign w_reach   = w_lb_zero || (w_col_rem >= {1'b0, r_lb});
    assign w_fin     = w_row_p1 >= r_height;
    assign w_slot    = !r_out_valid || o_pix.ready;
    assign w_emit    = (r_state == ST_RUN) && w_vis && w_slot;
    // last visible pixel of the run: later ones are padding or past the width
    assign w_last    = (r_rem == 6'd1) || (w_col_p1 >= r_width) || w_rowend;
    assign w_end     = w_last && w_reach && w_fin;

    always_comb begin
        n_state     = r_state;
        n_pend      = r_pend;
        n_pcnt      = r_pcnt;
        n_rem       = r_rem;
        n_col       = r_col;
        n_row       = r_row;
        n_done      = r_done;
        n_out_valid = r_out_valid && !o_pix.ready;
        if (w_emit) begin
            n_out_valid = 1'b1;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    case (i_req.req_type)
                        pcx_pkg::REQ_START: begin
                            n_pend = 1'b0;
                            n_pcnt = '0;
                            n_col  = '0;
                            n_row  = '0;
                            n_done = 1'b0;
                        end
                        pcx_pkg::REQ_DATA: begin
                            if (r_done || (r_row >= r_height)) begin
                                n_done = 1'b1;
                            end else if (r_pend) begin
                                n_pend = 1'b0;
                                n_pcnt = '0;
                                n_rem  = r_pcnt;
                                if (r_pcnt != '0) begin
                                    n_state = ST_RUN;
                                end
                            end else if (i_req.data_byte >= pcx_pkg::RUN_MARK) begin
                                n_pend = 1'b1;
                                n_pcnt = i_req.data_byte[pcx_pkg::RUN_W-1:0];
                            end else begin
                                n_rem   = 6'd1;
                                n_state = ST_RUN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                if (!w_vis) begin
                    // nothing more to show: skip the rest of the run in one step
                    n_state = ST_IDLE;
                    if (w_reach) begin
                        n_col = '0;
                        n_row = w_row_p1;
                        if (w_fin) begin
                            n_done = 1'b1;
                        end
                    end else begin
                        n_col = w_col_rem[15:0];
                    end
                end else if (w_slot) begin
                    if (w_rowend) begin
                        n_state = ST_IDLE;
                        n_col   = '0;
                        n_row   = w_row_p1;
                        if (w_fin) begin
                            n_done = 1'b1;
                        end
                    end else begin
                        n_col = w_col_p1[15:0];
                        n_rem = r_rem - 6'd1;
                        if (r_rem == 6'd1) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend      <= 1'b0;
            r_pcnt      <= '0;
            r_rem       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
            r_width     <= pcx_pkg::RST_WIDTH;
            r_height    <= pcx_pkg::RST_HEIGHT;
            r_lb        <= pcx_pkg::RST_LBYTES;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_pcnt      <= n_pcnt;
            r_rem       <= n_rem;
            r_col       <= n_col;
            r_row       <= n_row;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pcx_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                    pcx_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                    pcx_pkg::CFG_LBYTES: r_lb     <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_rgb  <= w_pal_rgb;
            r_out_col  <= r_col;
            r_out_row  <= r_row[15:0];
            r_out_last <= w_last;
            r_out_end  <= w_end;
        end
    end

    assign o_pix.valid       = r_out_valid;
    assign o_pix.red         = r_out_rgb.red;
    assign o_pix.green       = r_out_rgb.green;
    assign o_pix.blue        = r_out_rgb.blue;
    assign o_pix.pixel_col   = r_out_col;
    assign o_pix.pixel_row   = r_out_row;
    assign o_pix.last_of_run = r_out_last;
    assign o_pix.image_end   = r_out_end;

    a_rem_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_rem != '0))
        else $error("run active with no pixels left");

    a_run_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> !r_done)
        else $error("run active after image finished");

    a_last_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_last) |=> ((r_state == ST_IDLE) || !w_vis))
        else $error("visible pixel after last of run");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_end) |-> r_out_last)
        else $error("image end without last of run");

endmodule

/* design/pcx_palette.sv */
module pcx_palette (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [7:0]    i_wr_idx,
    input  pcx_pkg::t_rgb i_wr_rgb,
    input  logic          i_rd_en,
    input  logic [7:0]    i_rd_idx,
    output pcx_pkg::t_rgb o_rd_rgb
);

    pcx_pkg::t_rgb r_mem [pcx_pkg::PAL_ENTRIES];
    pcx_pkg::t_rgb r_rd;
    logic          r_oob;

    logic w_wr_ok;
    logic w_rd_ok;

    // indexes past the table are dropped on write and read back as black
    assign w_wr_ok = {1'b0, i_wr_idx} < 9'(pcx_pkg::PAL_ENTRIES);
    assign w_rd_ok = {1'b0, i_rd_idx} < 9'(pcx_pkg::PAL_ENTRIES);

    always_ff @(posedge i_clk) begin
        if (i_wr_en && w_wr_ok) begin
            r_mem[i_wr_idx[pcx_pkg::PAL_AW-1:0]] <= i_wr_rgb;
        end
        if (i_rd_en) begin
            r_rd  <= r_mem[i_rd_idx[pcx_pkg::PAL_AW-1:0]];
            r_oob <= !w_rd_ok;
        end
    end

    assign o_rd_rgb = r_oob ? '0 : r_rd;

endmodule
